### rtl/ctc_channel_register_model_unit_assert.svh
// ----------------------------------------------------------------------------
// CTC register model assertion macros
// Concurrent check shorthands; expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef CTC_CHANNEL_REGISTER_MODEL_UNIT_ASSERT_SVH
`define CTC_CHANNEL_REGISTER_MODEL_UNIT_ASSERT_SVH

// same-cycle implication
`define CTC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ctc_pkg.sv
// ----------------------------------------------------------------------------
// ctc_pkg
// Shared codes and types of the counter/timer register model.
// ----------------------------------------------------------------------------
package ctc_pkg;

  // access kinds
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_QUERY = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  // control word bits
  localparam int CW_IE_BIT    = 7;
  localparam int CW_MODE_BIT  = 6;
  localparam int CW_PRE_BIT   = 5;
  localparam int CW_TC_BIT    = 2;
  localparam int CW_CTRL_BIT  = 0;

  localparam logic [7:0] VEC_BASE_MASK = 8'hf8;
  localparam int         NUM_OVR       = 4;

  // post-access view of the addressed channel
  typedef struct packed {
    logic       ch_ok;
    logic [1:0] ch;
    logic [7:0] tc;
    logic       tc_valid;
    logic       mode;
    logic       pre256;
    logic       ie;
    logic       base_set;
    logic [7:0] base;
  } view_t;

  typedef struct packed {
    logic [16:0] timer_period;
    logic [8:0]  counter_divisor;
    logic [7:0]  irq_vector;
    logic        irq_enabled;
  } res_t;

endpackage

### rtl/ctc_chan_regs.sv
// ----------------------------------------------------------------------------
// ctc_chan_regs
// Per-channel state and vector base; applies one access per update.
// ----------------------------------------------------------------------------
module ctc_chan_regs #(
  parameter int NUM_CHANNELS = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                upd_en,
  input  logic [1:0]          act,
  input  logic [1:0]          ch,
  input  logic [7:0]          wdata,
  output ctc_pkg::view_t      view
);

  localparam int         CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [2:0] NCH    = 3'(NUM_CHANNELS);

  logic [7:0] tc_r     [NUM_CHANNELS];
  logic [7:0] tc_nxt   [NUM_CHANNELS];
  logic       tcv_r    [NUM_CHANNELS];
  logic       tcv_nxt  [NUM_CHANNELS];
  logic       exp_r    [NUM_CHANNELS];
  logic       exp_nxt  [NUM_CHANNELS];
  logic       mode_r   [NUM_CHANNELS];
  logic       mode_nxt [NUM_CHANNELS];
  logic       pre_r    [NUM_CHANNELS];
  logic       pre_nxt  [NUM_CHANNELS];
  logic       ie_r     [NUM_CHANNELS];
  logic       ie_nxt   [NUM_CHANNELS];
  logic [7:0] base_r, base_nxt;
  logic       bset_r, bset_nxt;

  logic            ch_ok;
  logic [CH_W-1:0] ch_idx;

  assign ch_ok  = ({1'b0, ch} < NCH);
  assign ch_idx = ch[CH_W-1:0];

  always_comb begin
    base_nxt = base_r;
    bset_nxt = bset_r;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      tc_nxt[i]   = tc_r[i];
      tcv_nxt[i]  = tcv_r[i];
      exp_nxt[i]  = exp_r[i];
      mode_nxt[i] = mode_r[i];
      pre_nxt[i]  = pre_r[i];
      ie_nxt[i]   = ie_r[i];
    end
    if (act == ctc_pkg::ACT_CLEAR) begin
      base_nxt = '0;
      bset_nxt = 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        tc_nxt[i]   = '0;
        tcv_nxt[i]  = 1'b0;
        exp_nxt[i]  = 1'b0;
        mode_nxt[i] = 1'b0;
        pre_nxt[i]  = 1'b0;
        ie_nxt[i]   = 1'b0;
      end
    end else if (act == ctc_pkg::ACT_WRITE && ch_ok) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        if (CH_W'(i) == ch_idx) begin
          if (exp_r[i]) begin
            tc_nxt[i]  = wdata;
            tcv_nxt[i] = 1'b1;
            exp_nxt[i] = 1'b0;
          end else if (!wdata[ctc_pkg::CW_CTRL_BIT]) begin
            // vector base only lands on channel 0
            if (i == 0) begin
              base_nxt = wdata & ctc_pkg::VEC_BASE_MASK;
              bset_nxt = 1'b1;
            end
          end else begin
            mode_nxt[i] = wdata[ctc_pkg::CW_MODE_BIT];
            pre_nxt[i]  = wdata[ctc_pkg::CW_PRE_BIT];
            ie_nxt[i]   = wdata[ctc_pkg::CW_IE_BIT];
            exp_nxt[i]  = wdata[ctc_pkg::CW_TC_BIT];
            if (wdata[ctc_pkg::CW_TC_BIT]) begin
              tcv_nxt[i] = 1'b0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      bset_r <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        tc_r[i]   <= '0;
        tcv_r[i]  <= 1'b0;
        exp_r[i]  <= 1'b0;
        mode_r[i] <= 1'b0;
        pre_r[i]  <= 1'b0;
        ie_r[i]   <= 1'b0;
      end
    end else if (upd_en) begin
      base_r <= base_nxt;
      bset_r <= bset_nxt;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        tc_r[i]   <= tc_nxt[i];
        tcv_r[i]  <= tcv_nxt[i];
        exp_r[i]  <= exp_nxt[i];
        mode_r[i] <= mode_nxt[i];
        pre_r[i]  <= pre_nxt[i];
        ie_r[i]   <= ie_nxt[i];
      end
    end
  end

  // channel as it stands after this access
  always_comb begin
    view          = '0;
    view.ch_ok    = ch_ok;
    view.ch       = ch;
    view.base_set = bset_nxt;
    view.base     = base_nxt;
    if (ch_ok) begin
      view.tc       = tc_nxt[ch_idx];
      view.tc_valid = tcv_nxt[ch_idx];
      view.mode     = mode_nxt[ch_idx];
      view.pre256   = pre_nxt[ch_idx];
      view.ie       = ie_nxt[ch_idx];
    end
  end

endmodule

### rtl/ctc_result.sv
// ----------------------------------------------------------------------------
// ctc_result
// Period, divisor, vector and enable for the addressed channel.
// ----------------------------------------------------------------------------
module ctc_result (
  input  logic                               [8:0] ovr [ctc_pkg::NUM_OVR],
  input  ctc_pkg::view_t                           view,
  output ctc_pkg::res_t                            res
);

  logic [8:0] tc_eff;
  logic [8:0] ovr_sel;
  logic [7:0] ch_x2;

  assign tc_eff  = (view.tc == 8'd0) ? 9'd256 : {1'b0, view.tc};
  assign ovr_sel = ovr[view.ch];
  assign ch_x2   = {5'd0, view.ch, 1'b0};

  always_comb begin
    res = '0;
    if (view.ch_ok) begin
      if (view.tc_valid) begin
        if (view.mode) begin
          res.counter_divisor = tc_eff;
        end else if (view.pre256) begin
          res.timer_period = {tc_eff, 8'd0};
        end else begin
          res.timer_period = {4'd0, tc_eff, 4'd0};
        end
      end
      if (view.base_set) begin
        res.irq_vector = view.base + ch_x2;
      end else if (!ovr_sel[8]) begin
        res.irq_vector = ovr_sel[7:0];
      end else begin
        res.irq_vector = ch_x2;
      end
      res.irq_enabled = view.ie;
    end
  end

endmodule

### rtl/ctc_channel_register_model_unit.sv
// ----------------------------------------------------------------------------
// ctc_channel_register_model_unit
// Four-channel counter/timer register model: one request in, one result out.
// ----------------------------------------------------------------------------
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+----------------------
//  in      | in_action, in_channel, in_write_data    | in_valid / in_stall
//  out     | out_timer_period, out_counter_divisor,  | out_valid / out_stall
//          | out_irq_vector, out_irq_enabled         |
//  cfg     | cfg_index, cfg_data                     | cfg_valid / cfg_ready
//
//  A request passes the input register, then state update and result
//  register. One request per cycle is sustained while out_stall is low.
//  Reset (rst_n low, synchronous) clears channel state and sets all vector
//  overrides to none. A stall on the result side holds the result register
//  and, once it is full, backs up into the input register and in_stall.
// ----------------------------------------------------------------------------
module ctc_channel_register_model_unit #(
  parameter int NUM_CHANNELS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [1:0]  in_channel,
  input  logic [7:0]  in_write_data,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [16:0] out_timer_period,
  output logic [8:0]  out_counter_divisor,
  output logic [7:0]  out_irq_vector,
  output logic        out_irq_enabled,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic signed [8:0] cfg_data
);

  // override registers; bit8 set means none
  logic [8:0] ovr_r [ctc_pkg::NUM_OVR];

  // input register
  logic       s1_valid_r;
  logic [1:0] s1_act_r;
  logic [1:0] s1_ch_r;
  logic [7:0] s1_data_r;

  // result register
  logic          out_valid_r;
  ctc_pkg::res_t res_r;
  ctc_pkg::res_t res_nxt;

  ctc_pkg::view_t view;
  logic           adv;

  // result stage moves when it is empty or being taken
  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ctc_pkg::NUM_OVR; i++) begin
        ovr_r[i] <= 9'h1ff;
      end
    end else if (cfg_valid) begin
      ovr_r[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_act_r  <= in_action;
      s1_ch_r   <= in_channel;
      s1_data_r <= in_write_data;
    end
  end

  // state commits only when the request moves into the result register
  ctc_chan_regs #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd_en (s1_valid_r && adv),
    .act    (s1_act_r),
    .ch     (s1_ch_r),
    .wdata  (s1_data_r),
    .view   (view)
  );

  ctc_result u_result (
    .ovr  (ovr_r),
    .view (view),
    .res  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_timer_period    = res_r.timer_period;
  assign out_counter_divisor = res_r.counter_divisor;
  assign out_irq_vector      = res_r.irq_vector;
  assign out_irq_enabled     = res_r.irq_enabled;

`include "ctc_channel_register_model_unit_assert.svh"

  // timer and counter modes exclude each other
  `CTC_ASSERT_NOW(a_mode_excl, out_valid, (out_timer_period == 17'd0) || (out_counter_divisor == 9'd0), "period and divisor both set")

  // divisor never beyond 256
  `CTC_ASSERT_NOW(a_div_range, out_valid, out_counter_divisor <= 9'd256, "divisor out of range")

  // a clear leaves the reported channel idle
  `CTC_ASSERT_NEXT(a_clear_idle, s1_valid_r && adv && (s1_act_r == ctc_pkg::ACT_CLEAR), out_valid && (out_timer_period == 17'd0) && (out_counter_divisor == 9'd0) && !out_irq_enabled, "clear left channel state")

  // stall only with a request held
  `CTC_ASSERT_NOW(a_stall_held, in_stall, s1_valid_r && out_valid_r, "stall without held request")

endmodule
